// ===== rtl/core/nll_pkg.sv =====
`default_nettype none

package nll_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned DIGIT_W  = 4;

    typedef logic [CH_W-1:0]     char_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [DIGIT_W-1:0]  digit_t;

    localparam mode_t MODE_IDLE = 3'd0;
    localparam mode_t MODE_ZERO = 3'd1;
    localparam mode_t MODE_DEC  = 3'd2;
    localparam mode_t MODE_HEX  = 3'd3;
    localparam mode_t MODE_OCT  = 3'd4;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_BADHEX = 3'd1;
    localparam status_t ST_BADOCT = 3'd2;
    localparam status_t ST_FLOAT  = 3'd3;
    localparam status_t ST_OVF    = 3'd4;

    localparam char_t CH_DIG_0   = 8'h30;
    localparam char_t CH_DIG_7   = 8'h37;
    localparam char_t CH_DIG_8   = 8'h38;
    localparam char_t CH_DIG_9   = 8'h39;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_F = 8'h66;
    localparam char_t CH_LOWER_Z = 8'h7a;
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_G = 8'h47;
    localparam char_t CH_UPPER_Z = 8'h5a;
    localparam char_t CH_X       = 8'h78;
    localparam char_t CH_O       = 8'h6f;
    localparam char_t CH_DOT     = 8'h2e;

    // What one step hands to the result register.
    typedef struct packed {
        logic    emit;
        status_t status;
        logic    pushed_back;
        logic    value_zero;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/number_literal_lexer_top.sv =====
// A result passes from the input register through the step logic into the result register.
// One character per cycle while the result register is not stalled; the mode and accumulator update is the loop.
// A full result register that is not taken stalls the step stage and then the input register.
// Reset (rst_n low, asynchronous) returns to idle with a zero value and no overflow,
// and empties both the input and the result register.
`default_nettype none

module number_literal_lexer_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         start_req,
    input  wire logic [nll_pkg::CH_W-1:0]     ch,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [nll_pkg::VALUE_W-1:0]       value,
    output logic [nll_pkg::STATUS_W-1:0]      status,
    output logic                              pushed_back
);

    logic                     in_valid_reg;
    logic                     start_reg;
    nll_pkg::char_t           ch_reg;
    nll_pkg::mode_t           mode_reg;
    nll_pkg::mode_t           mode_next;
    logic [VALUE_BITS-1:0]    acc_reg;
    logic [VALUE_BITS-1:0]    acc_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    nll_pkg::res_t            res;
    logic                     advance;
    logic                     out_valid_reg;
    logic [nll_pkg::VALUE_W-1:0] value_reg;
    nll_pkg::status_t         status_reg;
    logic                     pushed_back_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            start_reg <= start_req;
            ch_reg    <= ch;
        end
    end

    nll_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .start_req (start_reg),
        .ch        (ch_reg),
        .mode      (mode_reg),
        .acc       (acc_reg),
        .ovf       (ovf_reg),
        .mode_next (mode_next),
        .acc_next  (acc_next),
        .ovf_next  (ovf_next),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= nll_pkg::MODE_IDLE;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            value_reg       <= res.value_zero ? '0 : nll_pkg::VALUE_W'(acc_reg);
            status_reg      <= res.status;
            pushed_back_reg <= res.pushed_back;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign status      = status_reg;
    assign pushed_back = pushed_back_reg;

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == nll_pkg::MODE_IDLE) |-> ((acc_reg == '0) && !ovf_reg))
        else $error("idle mode with a nonzero accumulator or overflow flag");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (acc_reg == {VALUE_BITS{1'b1}}))
        else $error("overflow flag set without a saturated accumulator");

    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((status_reg == nll_pkg::ST_BADHEX)
            || (status_reg == nll_pkg::ST_BADOCT) || (status_reg == nll_pkg::ST_FLOAT)))
        |-> ((value_reg == '0) && !pushed_back_reg))
        else $error("error beat with a nonzero value or a pushed back character");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(mode_reg) && $stable(acc_reg)))
        else $error("step state moved while the result register was stalled");

endmodule

`default_nettype wire

// ===== rtl/core/nll_step.sv =====
`default_nettype none

module nll_step #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  start_req,
    input  wire nll_pkg::char_t        ch,
    input  wire nll_pkg::mode_t        mode,
    input  wire logic [VALUE_BITS-1:0] acc,
    input  wire logic                  ovf,
    output nll_pkg::mode_t             mode_next,
    output logic [VALUE_BITS-1:0]      acc_next,
    output logic                       ovf_next,
    output nll_pkg::res_t              res
);

    localparam int unsigned WIDE_W = VALUE_BITS + 4;

    logic                 is_dig;
    logic                 is_lower_hex;
    logic                 is_upper_hex;
    logic                 is_alnum;
    logic                 is_oct;
    nll_pkg::digit_t      digit;
    logic [WIDE_W-1:0]    acc_wide;
    logic [WIDE_W-1:0]    prod;
    logic [WIDE_W-1:0]    sum;
    logic                 mac_sat;
    logic [VALUE_BITS-1:0] mac_acc;
    logic                 mac_ovf;
    nll_pkg::mode_t       mode_eff;

    assign is_dig       = (ch >= nll_pkg::CH_DIG_0) && (ch <= nll_pkg::CH_DIG_9);
    assign is_oct       = (ch >= nll_pkg::CH_DIG_0) && (ch <= nll_pkg::CH_DIG_7);
    assign is_lower_hex = (ch >= nll_pkg::CH_LOWER_A) && (ch <= nll_pkg::CH_LOWER_F);
    assign is_upper_hex = (ch >= nll_pkg::CH_UPPER_A) && (ch < nll_pkg::CH_UPPER_G);
    assign is_alnum     = is_dig
                        || ((ch >= nll_pkg::CH_LOWER_A) && (ch <= nll_pkg::CH_LOWER_Z))
                        || ((ch >= nll_pkg::CH_UPPER_A) && (ch <= nll_pkg::CH_UPPER_Z));

    // Letters a-f and A-F both have low nibbles 1..6, so adding nine gives 10..15.
    assign digit = is_dig ? ch[3:0] : nll_pkg::digit_t'(ch[3:0] + 4'd9);

    // A lone zero followed by anything but a prefix letter continues as decimal.
    always_comb
    begin
        mode_eff = mode;
        if ((mode == nll_pkg::MODE_ZERO) && (ch != nll_pkg::CH_X) && (ch != nll_pkg::CH_O))
        begin
            mode_eff = nll_pkg::MODE_DEC;
        end
    end

    assign acc_wide = WIDE_W'(acc);

    always_comb
    begin
        unique case (mode_eff)
            nll_pkg::MODE_HEX: prod = acc_wide << 4;
            nll_pkg::MODE_OCT: prod = acc_wide << 3;
            default:           prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
    end

    assign sum     = prod + WIDE_W'(digit);
    assign mac_sat = ovf || (sum[WIDE_W-1:VALUE_BITS] != '0);
    assign mac_acc = mac_sat ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
    assign mac_ovf = mac_sat;

    always_comb
    begin
        mode_next = mode;
        acc_next  = acc;
        ovf_next  = ovf;
        res       = '0;

        if (start_req)
        begin
            mode_next = nll_pkg::MODE_IDLE;
            acc_next  = '0;
            ovf_next  = 1'b0;
            if (ch == nll_pkg::CH_DOT)
            begin
                res.emit       = 1'b1;
                res.status     = nll_pkg::ST_FLOAT;
                res.value_zero = 1'b1;
            end
            else if (ch == nll_pkg::CH_DIG_0)
            begin
                mode_next = nll_pkg::MODE_ZERO;
            end
            else if (is_dig)
            begin
                mode_next = nll_pkg::MODE_DEC;
                acc_next  = VALUE_BITS'(digit);
            end
        end
        else
        begin
            unique case (mode_eff)
                nll_pkg::MODE_ZERO:
                begin
                    mode_next = (ch == nll_pkg::CH_X) ? nll_pkg::MODE_HEX : nll_pkg::MODE_OCT;
                end
                nll_pkg::MODE_DEC:
                begin
                    mode_next = nll_pkg::MODE_DEC;
                    if (is_dig)
                    begin
                        acc_next = mac_acc;
                        ovf_next = mac_ovf;
                    end
                    else
                    begin
                        res.emit = 1'b1;
                        if (ch == nll_pkg::CH_DOT)
                        begin
                            res.status     = nll_pkg::ST_FLOAT;
                            res.value_zero = 1'b1;
                        end
                        else
                        begin
                            res.status      = ovf ? nll_pkg::ST_OVF : nll_pkg::ST_OK;
                            res.pushed_back = 1'b1;
                        end
                    end
                end
                nll_pkg::MODE_HEX:
                begin
                    if (is_dig || is_lower_hex || is_upper_hex)
                    begin
                        acc_next = mac_acc;
                        ovf_next = mac_ovf;
                    end
                    else if (is_alnum)
                    begin
                        res.emit       = 1'b1;
                        res.status     = nll_pkg::ST_BADHEX;
                        res.value_zero = 1'b1;
                    end
                    else
                    begin
                        res.emit        = 1'b1;
                        res.status      = ovf ? nll_pkg::ST_OVF : nll_pkg::ST_OK;
                        res.pushed_back = 1'b1;
                    end
                end
                nll_pkg::MODE_OCT:
                begin
                    if (is_oct)
                    begin
                        acc_next = mac_acc;
                        ovf_next = mac_ovf;
                    end
                    else if ((ch == nll_pkg::CH_DIG_8) || (ch == nll_pkg::CH_DIG_9))
                    begin
                        res.emit       = 1'b1;
                        res.status     = nll_pkg::ST_BADOCT;
                        res.value_zero = 1'b1;
                    end
                    else
                    begin
                        res.emit        = 1'b1;
                        res.status      = ovf ? nll_pkg::ST_OVF : nll_pkg::ST_OK;
                        res.pushed_back = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = nll_pkg::MODE_IDLE;
                end
            endcase

            if (res.emit)
            begin
                mode_next = nll_pkg::MODE_IDLE;
                acc_next  = '0;
                ovf_next  = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_AT_BEAT = 700;
    localparam int HOLD_CYCLES  = 400;

    localparam nll_pkg::char_t CH_SPACE = 8'h20;
    localparam nll_pkg::char_t CH_SEMI  = 8'h3b;
    localparam nll_pkg::char_t CH_COMMA = 8'h2c;
    localparam nll_pkg::char_t CH_NL    = 8'h0a;
    localparam nll_pkg::char_t CH_LOWER_G = 8'h67;

    typedef struct packed {
        logic           start;
        nll_pkg::char_t ch;
        logic           calm;
        logic           drain;
    } char_item_t;

    typedef struct packed {
        logic [nll_pkg::VALUE_W-1:0] value;
        nll_pkg::status_t            status;
        logic                        pushed_back;
    } lit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         start_req = 1'b0;
    nll_pkg::char_t               ch = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [nll_pkg::VALUE_W-1:0]  value;
    nll_pkg::status_t             status;
    logic                         pushed_back;

    char_item_t  pending_chars[$];
    lit_result_t lit_results[$];

    // Lexer state as the block should hold it.
    nll_pkg::mode_t lx_mode = nll_pkg::MODE_IDLE;
    logic [63:0]    lx_acc = '0;
    logic           lx_ovf = 1'b0;

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic calm_now = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   in_beats = 0;
    int   n_mismatch = 0;

    logic gen_calm = 1'b0;
    logic drain_next = 1'b0;

    number_literal_lexer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_req   (start_req),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .status      (status),
        .pushed_back (pushed_back)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_digit(input nll_pkg::char_t c);
        return c >= nll_pkg::CH_DIG_0 && c <= nll_pkg::CH_DIG_9;
    endfunction

    function automatic bit is_letter_or_digit(input nll_pkg::char_t c);
        return is_digit(c) || (c >= nll_pkg::CH_LOWER_A && c <= nll_pkg::CH_LOWER_Z)
            || (c >= nll_pkg::CH_UPPER_A && c <= nll_pkg::CH_UPPER_Z);
    endfunction

    // Once saturated, the value stays at the maximum for the rest of the literal.
    task automatic add_digit(input int unsigned base, input int unsigned d);
        logic [63:0] max_val;
        max_val = (64'd1 << nll_pkg::VALUE_W) - 64'd1;
        if (lx_ovf || lx_acc > (max_val - 64'(d)) / 64'(base))
        begin
            lx_acc = max_val;
            lx_ovf = 1'b1;
        end
        else
        begin
            lx_acc = lx_acc * 64'(base) + 64'(d);
        end
    endtask

    task automatic close_literal(input logic [nll_pkg::VALUE_W-1:0] v,
                                 input nll_pkg::status_t st, input logic pb);
        lit_results.push_back('{v, st, pb});
        lx_mode = nll_pkg::MODE_IDLE;
        lx_acc = '0;
        lx_ovf = 1'b0;
    endtask

    task automatic close_clean();
        close_literal(lx_acc[nll_pkg::VALUE_W-1:0],
                      lx_ovf ? nll_pkg::ST_OVF : nll_pkg::ST_OK, 1'b1);
    endtask

    task automatic lex_char(input logic st, input nll_pkg::char_t c);
        nll_pkg::mode_t m;
        if (st)
        begin
            lx_acc = '0;
            lx_ovf = 1'b0;
            lx_mode = nll_pkg::MODE_IDLE;
            if (c == nll_pkg::CH_DOT)
                close_literal('0, nll_pkg::ST_FLOAT, 1'b0);
            else if (c == nll_pkg::CH_DIG_0)
                lx_mode = nll_pkg::MODE_ZERO;
            else if (is_digit(c))
            begin
                lx_mode = nll_pkg::MODE_DEC;
                add_digit(10, 32'(c - nll_pkg::CH_DIG_0));
            end
            return;
        end
        m = lx_mode;
        if (m == nll_pkg::MODE_ZERO)
        begin
            if (c == nll_pkg::CH_X)
            begin
                lx_mode = nll_pkg::MODE_HEX;
                return;
            end
            if (c == nll_pkg::CH_O)
            begin
                lx_mode = nll_pkg::MODE_OCT;
                return;
            end
            // A lone zero carries on as a decimal literal.
            lx_mode = nll_pkg::MODE_DEC;
            m = nll_pkg::MODE_DEC;
        end
        case (m)
            nll_pkg::MODE_DEC:
            begin
                if (is_digit(c))
                    add_digit(10, 32'(c - nll_pkg::CH_DIG_0));
                else if (c == nll_pkg::CH_DOT)
                    close_literal('0, nll_pkg::ST_FLOAT, 1'b0);
                else
                    close_clean();
            end
            nll_pkg::MODE_HEX:
            begin
                if (is_digit(c))
                    add_digit(16, 32'(c - nll_pkg::CH_DIG_0));
                else if (c >= nll_pkg::CH_LOWER_A && c <= nll_pkg::CH_LOWER_F)
                    add_digit(16, 32'(c - nll_pkg::CH_LOWER_A) + 32'd10);
                else if (c >= nll_pkg::CH_UPPER_A && c < nll_pkg::CH_UPPER_G)
                    add_digit(16, 32'(c - nll_pkg::CH_UPPER_A) + 32'd10);
                else if (is_letter_or_digit(c))
                    close_literal('0, nll_pkg::ST_BADHEX, 1'b0);
                else
                    close_clean();
            end
            nll_pkg::MODE_OCT:
            begin
                if (c >= nll_pkg::CH_DIG_0 && c <= nll_pkg::CH_DIG_7)
                    add_digit(8, 32'(c - nll_pkg::CH_DIG_0));
                else if (c == nll_pkg::CH_DIG_8 || c == nll_pkg::CH_DIG_9)
                    close_literal('0, nll_pkg::ST_BADOCT, 1'b0);
                else
                    close_clean();
            end
            default:
                lx_mode = nll_pkg::MODE_IDLE;
        endcase
    endtask

    task automatic add_char(input logic st, input nll_pkg::char_t c);
        pending_chars.push_back('{st, c, gen_calm, drain_next});
        drain_next = 1'b0;
    endtask

    function automatic nll_pkg::char_t rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 21);
        if (v < 10)
            return nll_pkg::char_t'(nll_pkg::CH_DIG_0 + v);
        else if (v < 16)
            return nll_pkg::char_t'(nll_pkg::CH_LOWER_A + v - 10);
        else
            return nll_pkg::char_t'(nll_pkg::CH_UPPER_A + v - 16);
    endfunction

    function automatic nll_pkg::char_t rand_closer();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_SEMI;
            2: return CH_COMMA;
            3: return nll_pkg::char_t'($urandom_range(0, 255));
            4: return nll_pkg::char_t'(nll_pkg::CH_LOWER_A + $urandom_range(0, 25));
            5: return $urandom_range(0, 1) ? nll_pkg::CH_DIG_8 : nll_pkg::CH_DIG_9;
            6: return nll_pkg::CH_DOT;
            default: return CH_NL;
        endcase
    endfunction

    // One literal with random content, or a burst of noise characters.
    task automatic add_random_literal();
        int unsigned kind;
        int unsigned n;
        bit          open_end;
        kind = $urandom_range(0, 19);
        open_end = 1'b0;
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 4))
                add_char(1'($urandom_range(0, 1)), nll_pkg::char_t'($urandom_range(0, 255)));
            return;
        end
        if (kind < 8)
        begin
            add_char(1'b1, nll_pkg::char_t'(nll_pkg::CH_DIG_0 + $urandom_range(0, 9)));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 6);
            repeat (n)
                add_char(1'b0, nll_pkg::char_t'(nll_pkg::CH_DIG_0 + $urandom_range(0, 9)));
        end
        else if (kind < 12)
        begin
            add_char(1'b1, nll_pkg::CH_DIG_0);
            add_char(1'b0, nll_pkg::CH_X);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 6);
            repeat (n)
                add_char(1'b0, rand_hex_char());
        end
        else if (kind < 16)
        begin
            add_char(1'b1, nll_pkg::CH_DIG_0);
            add_char(1'b0, nll_pkg::CH_O);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 6);
            repeat (n)
                add_char(1'b0, nll_pkg::char_t'(nll_pkg::CH_DIG_0 + $urandom_range(0, 7)));
        end
        else if (kind == 16)
        begin
            if ($urandom_range(0, 1))
                add_char(1'b1, nll_pkg::char_t'(nll_pkg::CH_DIG_0 + $urandom_range(1, 9)));
            else
                add_char(1'b1, nll_pkg::CH_DOT);
        end
        else if (kind == 17)
        begin
            add_char(1'b1, nll_pkg::CH_DIG_0);
        end
        else
        begin
            // No closer is added; a later character or the next literal's start ends it.
            add_char(1'b1, nll_pkg::char_t'(nll_pkg::CH_DIG_0 + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 3))
                add_char(1'b0, rand_hex_char());
            open_end = 1'b1;
        end
        if (!open_end)
            add_char(1'b0, rand_closer());
    endtask

    always @(negedge clk)
    begin : drive_chars
        char_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
            // The beat is still on offer.
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_chars.size() != 0
                 && !(pending_chars[0].drain && lit_results.size() != 0))
        begin
            it = pending_chars.pop_front();
            in_valid  <= 1'b1;
            start_req <= it.start;
            ch        <= it.ch;
            calm_now  <= it.calm;
            gap_left  <= it.calm ? 0 : int'($urandom_range(0, 12));
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : hold_off
        if (rst_n && !hold_done && in_beats >= HOLD_AT_BEAT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        int unsigned d;
        if (!rst_n || hold_left != 0)
        begin
            out_ready <= 1'b0;
        end
        else if (out_fire)
        begin
            d = calm_now ? 0 : $urandom_range(0, 12);
            if (d == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                stall_left <= int'(d) - 1;
            end
        end
        else if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_beats
        lit_result_t want;
        in_fire  <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (lit_results.size() == 0)
            begin
                if (n_mismatch < 10)
                    $display("unexpected result: value %h status %0d pushed_back %0b",
                             value, status, pushed_back);
                n_mismatch++;
            end
            else
            begin
                want = lit_results.pop_front();
                if (value !== want.value || status !== want.status
                    || pushed_back !== want.pushed_back)
                begin
                    if (n_mismatch < 10)
                        $display("mismatch: value %h/%h status %0d/%0d pushed_back %0b/%0b",
                                 want.value, value, want.status, status,
                                 want.pushed_back, pushed_back);
                    n_mismatch++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            lex_char(start_req, ch);
            in_beats++;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        // Character ignored while idle, then a start that is not a digit.
        add_char(1'b0, 8'hff);
        add_char(1'b1, 8'h00);
        // Bad hex letter.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_X);
        add_char(1'b0, CH_LOWER_G);
        // Octal digit eight.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_O);
        add_char(1'b0, nll_pkg::CH_DIG_8);
        // Float forms.
        add_char(1'b1, nll_pkg::CH_DOT);
        add_char(1'b1, nll_pkg::CH_DIG_9);
        add_char(1'b0, nll_pkg::CH_DOT);
        // An open octal literal dropped by a new start, then closed by a letter.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_O);
        add_char(1'b1, nll_pkg::CH_DIG_7);
        add_char(1'b0, nll_pkg::CH_LOWER_Z);
        // Empty hex prefix.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_X);
        add_char(1'b0, CH_SPACE);
        // Octal literal closed by a letter.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_O);
        add_char(1'b0, nll_pkg::CH_DIG_7);
        add_char(1'b0, nll_pkg::CH_UPPER_Z);
        // Lone zero continued as decimal, and hex saturation.
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_DIG_9);
        add_char(1'b1, nll_pkg::CH_DIG_0);
        add_char(1'b0, nll_pkg::CH_X);
        repeat (9)
            add_char(1'b0, nll_pkg::char_t'(nll_pkg::CH_UPPER_A + 8'd5));
        add_char(1'b0, 8'hff);

        while (pending_chars.size() < 500)
            add_random_literal();
        gen_calm = 1'b1;
        while (pending_chars.size() < 1000)
            add_random_literal();
        gen_calm = 1'b0;
        drain_next = 1'b1;
        while (pending_chars.size() < 1450)
            add_random_literal();
        drain_next = 1'b1;
        while (pending_chars.size() < 1900)
            add_random_literal();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid)
            @(posedge clk);
        while (lit_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (n_mismatch == 0 && lit_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
